// ===== rtl/crc8fa_pkg.sv =====
`default_nettype none
package crc8fa_pkg;

  localparam int STORE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] CRC_POLY = 8'h97;

  // frame kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_TWO   = 2'd2;

  // append size codes (anything else is four bytes)
  localparam logic [1:0] SIZE_ONE = 2'd0;
  localparam logic [1:0] SIZE_TWO = 2'd1;

  // register reset values
  localparam logic [1:0] RST_FRAME_KIND = KIND_ONE;
  localparam logic       RST_CRC_ENABLE = 1'b1;
  localparam logic [7:0] RST_HEADER     = 8'hCC;
  localparam logic [7:0] RST_CAPACITY   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_KIND     = 3'd0,
    REG_CRC_ENABLE     = 3'd1,
    REG_FIRST_HEADER   = 3'd2,
    REG_SECOND_HEADER  = 3'd3,
    REG_FRAME_CAPACITY = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_COMMIT = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_COMMITTED = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic       crc_enable;
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] frame_capacity;
  } cfg_t;

  // classified request, as queued between front and back
  typedef struct packed {
    op_t         op;
    logic [31:0] data_word;
    logic [2:0]  cnt;       // append byte count: 1, 2 or 4
    logic [7:0]  data_crc;  // CRC of the append bytes alone, init 0
    logic [7:0]  read_index;
  } cmd_t;

  // store access for one executed request
  typedef struct packed {
    logic [2:0]  wr_cnt;    // bytes written from wr_base, 0 = none
    logic [7:0]  wr_base;
    logic [31:0] wr_data;
    logic        patch_en;
    logic [1:0]  patch_idx;
    logic [7:0]  patch_val;
    logic        rd_en;
    logic [7:0]  rd_idx;
  } store_req_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // running CRC after the reset-time header-one start
  localparam logic [7:0] RST_CRC = crc_byte(crc_byte(8'h00, RST_HEADER), 8'h00);

endpackage
`default_nettype wire

// ===== rtl/crc8fa_if.sv =====
`default_nettype none
interface crc8fa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] data_word;
  logic [1:0]  size_code;
  logic [7:0]  read_index;

  modport source (output valid, op, data_word, size_code, read_index, input ready);
  modport sink (input valid, op, data_word, size_code, read_index, output ready);
endinterface

interface crc8fa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       error_flag;
  logic [7:0] frame_length;
  logic [7:0] crc_value;
  logic [7:0] read_value;

  modport source (output valid, status, error_flag, frame_length, crc_value, read_value,
                  input ready);
  modport sink (input valid, status, error_flag, frame_length, crc_value, read_value,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/crc8fa_front.sv =====
`default_nettype none
module crc8fa_front (
  input  logic               clk,
  input  logic               rst_n,
  crc8fa_in_if.sink          in_if,
  input  logic               q_pop,
  output logic               q_valid,
  output crc8fa_pkg::cmd_t   q_cmd
);
  import crc8fa_pkg::*;

  cmd_t       cmd_in;
  logic [7:0] c1, c2, c4;
  logic       push;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  // decode and precompute the data-only CRC of the append bytes
  always_comb begin
    c1 = crc_byte(8'h00, in_if.data_word[7:0]);
    c2 = crc_byte(c1, in_if.data_word[15:8]);
    c4 = crc_byte(crc_byte(c2, in_if.data_word[23:16]), in_if.data_word[31:24]);
    cmd_in.op         = op_t'(in_if.op);
    cmd_in.data_word  = in_if.data_word;
    cmd_in.read_index = in_if.read_index;
    unique case (in_if.size_code)
      SIZE_ONE: begin
        cmd_in.cnt      = 3'd1;
        cmd_in.data_crc = c1;
      end
      SIZE_TWO: begin
        cmd_in.cnt      = 3'd2;
        cmd_in.data_crc = c2;
      end
      default: begin
        cmd_in.cnt      = 3'd4;
        cmd_in.data_crc = c4;
      end
    endcase
  end

  // two-entry queue
  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= cmd_in;
  end

endmodule
`default_nettype wire

// ===== rtl/crc8fa_store.sv =====
`default_nettype none
module crc8fa_store #(
  parameter int STORE_DEPTH = crc8fa_pkg::STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crc8fa_pkg::store_req_t st_req,
  output logic [7:0]             rd_data
);
  import crc8fa_pkg::*;

  localparam int LANES      = 4;
  localparam int AW         = $clog2(STORE_DEPTH);
  localparam int BANK_DEPTH = (STORE_DEPTH + LANES - 1) / LANES;

  logic          lane_en   [LANES];
  logic [AW-1:0] lane_idx  [LANES];
  logic [7:0]    lane_data [LANES];
  logic [7:0]    bank_q    [LANES];

  // bytes 0..3 also live in flops: header/length patch and reset header
  logic [7:0] lo_r   [LANES];
  logic [7:0] lo_nxt [LANES];

  logic       rd_lo_sel_r;
  logic [7:0] rd_lo_r;
  logic [1:0] rd_bank_r;

  // byte lane k of the write goes to bank (base + k) mod 4
  always_comb begin
    logic [1:0] k;
    for (int b = 0; b < LANES; b++) begin
      k            = 2'(b) - st_req.wr_base[1:0];
      lane_en[b]   = ({1'b0, k} < st_req.wr_cnt);
      lane_idx[b]  = st_req.wr_base[AW-1:0] + AW'(k);
      lane_data[b] = st_req.wr_data[{k, 3'b000} +: 8];
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) lo_nxt[j] = lo_r[j];
    for (int b = 0; b < LANES; b++) begin
      if (lane_en[b] && (lane_idx[b] < AW'(LANES))) lo_nxt[lane_idx[b][1:0]] = lane_data[b];
    end
    if (st_req.patch_en) lo_nxt[st_req.patch_idx] = st_req.patch_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r[0] <= RST_HEADER;
      lo_r[1] <= 8'h00;
      lo_r[2] <= 8'h00;
      lo_r[3] <= 8'h00;
    end else begin
      for (int j = 0; j < LANES; j++) lo_r[j] <= lo_nxt[j];
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] q_r;

    always_ff @(posedge clk) begin
      if (lane_en[b]) mem[lane_idx[b][AW-1:2]] <= lane_data[b];
      if (st_req.rd_en) q_r <= mem[st_req.rd_idx[AW-1:2]];
    end

    assign bank_q[b] = q_r;
  end

  always_ff @(posedge clk) begin
    if (st_req.rd_en) begin
      rd_lo_sel_r <= (st_req.rd_idx < 8'(LANES));
      rd_lo_r     <= lo_r[st_req.rd_idx[1:0]];
      rd_bank_r   <= st_req.rd_idx[1:0];
    end
  end

  assign rd_data = rd_lo_sel_r ? rd_lo_r : bank_q[rd_bank_r];

endmodule
`default_nettype wire

// ===== rtl/crc8fa_back.sv =====
`default_nettype none
module crc8fa_back #(
  parameter int STORE_DEPTH = crc8fa_pkg::STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crc8fa_pkg::cfg_t       cfg,
  input  logic                   q_valid,
  input  crc8fa_pkg::cmd_t       q_cmd,
  output logic                   q_pop,
  output crc8fa_pkg::store_req_t st_req,
  input  logic [7:0]             rd_data,
  crc8fa_out_if.source           out_if
);
  import crc8fa_pkg::*;

  localparam logic [7:0] MAX_LIMIT = 8'(STORE_DEPTH - 1);

  logic [7:0] fill_r, fill_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       ovf_r, ovf_nxt;
  logic       cmt_r, cmt_nxt;

  logic       out_valid_r;
  status_t    status_r;
  logic       err_r;
  logic [7:0] len_r;
  logic [7:0] crco_r;
  logic       rd_ok_r;

  logic       fire;
  status_t    res_status;
  logic [7:0] res_crc;
  logic       res_rd_ok;

  logic [7:0] limit;
  logic [8:0] sum;
  logic [7:0] a1, a2, a4, adv;
  logic [7:0] s1, sk1, sk2;
  logic [7:0] cc, cf;
  logic       has_crc;

  assign fire  = q_valid && (!out_valid_r || out_if.ready);
  assign q_pop = fire;

  always_comb begin
    limit = (cfg.frame_capacity > MAX_LIMIT) ? MAX_LIMIT : cfg.frame_capacity;
    sum   = {1'b0, fill_r} + {6'b0, q_cmd.cnt};

    // running CRC pushed through n zero bytes; data part comes from the front
    a1 = crc_byte(crc_r, 8'h00);
    a2 = crc_byte(a1, 8'h00);
    a4 = crc_byte(crc_byte(a2, 8'h00), 8'h00);
    unique case (q_cmd.cnt)
      3'd1:    adv = a1;
      3'd2:    adv = a2;
      default: adv = a4;
    endcase

    s1  = crc_byte(8'h00, cfg.first_header);
    sk1 = crc_byte(s1, 8'h00);
    sk2 = crc_byte(crc_byte(s1, cfg.second_header), 8'h00);

    has_crc = ((cfg.frame_kind == KIND_ONE) || (cfg.frame_kind == KIND_TWO)) && cfg.crc_enable;
    cc      = (crc_r == 8'h00) ? 8'h01 : crc_r;
    cf      = has_crc ? (fill_r + 8'd1) : fill_r;
  end

  always_comb begin
    fill_nxt   = fill_r;
    crc_nxt    = crc_r;
    ovf_nxt    = ovf_r;
    cmt_nxt    = cmt_r;
    st_req     = '0;
    res_status = ST_OK;
    res_crc    = crc_r;
    res_rd_ok  = 1'b0;
    if (fire) begin
      unique case (q_cmd.op)
        OP_START: begin
          ovf_nxt        = 1'b0;
          cmt_nxt        = 1'b0;
          st_req.wr_base = 8'd0;
          priority if (cfg.frame_kind == KIND_ONE) begin
            fill_nxt       = 8'd2;
            crc_nxt        = sk1;
            st_req.wr_cnt  = 3'd2;
            st_req.wr_data = {24'h0, cfg.first_header};
          end else if (cfg.frame_kind == KIND_TWO) begin
            fill_nxt       = 8'd3;
            crc_nxt        = sk2;
            st_req.wr_cnt  = 3'd3;
            st_req.wr_data = {16'h0, cfg.second_header, cfg.first_header};
          end else begin
            fill_nxt       = 8'd1;
            crc_nxt        = 8'h00;
            st_req.wr_cnt  = 3'd1;
            st_req.wr_data = 32'h0;
          end
          res_crc = crc_nxt;
        end
        OP_APPEND: begin
          if (sum >= {1'b0, limit}) begin
            ovf_nxt    = 1'b1;
            res_status = ST_OVERFLOW;
          end else begin
            st_req.wr_cnt  = q_cmd.cnt;
            st_req.wr_base = fill_r;
            st_req.wr_data = q_cmd.data_word;
            fill_nxt       = sum[7:0];
            crc_nxt        = q_cmd.data_crc ^ adv;
            res_crc        = crc_nxt;
          end
        end
        OP_COMMIT: begin
          if (cmt_r) begin
            res_status = ST_COMMITTED;
          end else begin
            cmt_nxt  = 1'b1;
            fill_nxt = cf;
            if (has_crc) begin
              st_req.wr_cnt  = 3'd1;
              st_req.wr_base = fill_r;
              st_req.wr_data = {24'h0, cc};
              res_crc        = cc;
            end
            st_req.patch_en = 1'b1;
            priority if (cfg.frame_kind == KIND_ONE) begin
              st_req.patch_idx = 2'd1;
              st_req.patch_val = cf - 8'd2;
            end else if (cfg.frame_kind == KIND_TWO) begin
              st_req.patch_idx = 2'd2;
              st_req.patch_val = cf - 8'd3;
            end else begin
              st_req.patch_idx = 2'd0;
              st_req.patch_val = cf;
            end
          end
        end
        OP_READ: begin
          if (q_cmd.read_index >= fill_r) begin
            res_status = ST_BEYOND;
          end else begin
            st_req.rd_en  = 1'b1;
            st_req.rd_idx = q_cmd.read_index;
            res_rd_ok     = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 8'd2;
      crc_r       <= RST_CRC;
      ovf_r       <= 1'b0;
      cmt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      crc_r  <= crc_nxt;
      ovf_r  <= ovf_nxt;
      cmt_r  <= cmt_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= res_status;
      err_r    <= ovf_nxt;
      len_r    <= fill_nxt;
      crco_r   <= res_crc;
      rd_ok_r  <= res_rd_ok;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = status_r;
  assign out_if.error_flag   = err_r;
  assign out_if.frame_length = len_r;
  assign out_if.crc_value    = crco_r;
  assign out_if.read_value   = rd_ok_r ? rd_data : 8'h00;

endmodule
`default_nettype wire

// ===== rtl/crc8_frame_assembler_top.sv =====
`default_nettype none
// A request waits in the front queue and executes when the result register is empty or being
//   taken, and its result is registered. Throughput: one request per cycle while out_if.ready is
//   high; fill count and CRC update at once (four-byte CRC advance, four-lane store write).
// Reset (synchronous, rst_n low): registers to defaults, frame as after a one-header start
//   (length 2, running CRC of 0xCC 0x00); store banks are not cleared, no clearing pass.
module crc8_frame_assembler_top #(
  parameter int STORE_DEPTH = crc8fa_pkg::STORE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  crc8fa_in_if.sink                            in_if,
  crc8fa_out_if.source                         out_if,
  input  logic                                 cfg_we,
  input  logic [crc8fa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crc8fa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import crc8fa_pkg::*;

  cfg_t       cfg_r;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  store_req_t st_req;
  logic [7:0] rd_data;

  // config registers; the user must write them only while idle (not enforced here), so back end reads them live
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_kind     <= RST_FRAME_KIND;
      cfg_r.crc_enable     <= RST_CRC_ENABLE;
      cfg_r.first_header   <= RST_HEADER;
      cfg_r.second_header  <= RST_HEADER;
      cfg_r.frame_capacity <= RST_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_KIND:     cfg_r.frame_kind     <= cfg_wdata[1:0];
        REG_CRC_ENABLE:     cfg_r.crc_enable     <= cfg_wdata[0];
        REG_FIRST_HEADER:   cfg_r.first_header   <= cfg_wdata;
        REG_SECOND_HEADER:  cfg_r.second_header  <= cfg_wdata;
        REG_FRAME_CAPACITY: cfg_r.frame_capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accept, decode size, data CRC, two-entry request queue
  crc8fa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // back: frame state, store writes/reads, result register
  crc8fa_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .st_req  (st_req),
    .rd_data (rd_data),
    .out_if  (out_if)
  );

  // frame store: four byte-wide banks plus flops for bytes 0..3
  crc8fa_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .st_req  (st_req),
    .rd_data (rd_data)
  );

  // overflow status always comes with the sticky flag set
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == ST_OVERFLOW)) |-> out_if.error_flag)
    else $error("overflow status without error flag");

  // store reads only for an executing read request
  a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.rd_en |-> (q_pop && (q_cmd.op == OP_READ)))
    else $error("store read without read request");

  // every executed request lands in the result register
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_if.valid)
    else $error("executed request produced no result");

  // frame never grows past the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> ({1'b0, out_if.frame_length} < 9'(STORE_DEPTH)))
    else $error("frame length beyond store");

endmodule
`default_nettype wire
